@@ design/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the saddle point search block.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic gt_row;
      logic lt_col;
      logic eq_row;
      logic eq_col;
   } cmp_result_type;

endpackage

@@ design/msp_store.sv @@
// ----------------------------------------------------------------------------
// msp_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msp_store #(
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  msp_pkg::data_type wr_data,
   input  logic [AW-1:0]    rd_addr,
   output msp_pkg::data_type rd_data
);

   msp_pkg::data_type mem [1 << AW];
   msp_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/msp_cmp.sv @@
// ----------------------------------------------------------------------------
// msp_cmp
// Shared compare unit: one operand against a row bound and a column bound.
// ----------------------------------------------------------------------------
module msp_cmp (
   input  msp_pkg::data_type       operand,
   input  msp_pkg::data_type       row_bound,
   input  msp_pkg::data_type       col_bound,
   output msp_pkg::cmp_result_type result
);

   always_comb begin
      result.gt_row = operand > row_bound;
      result.lt_col = operand < col_bound;
      result.eq_row = operand == row_bound;
      result.eq_col = operand == col_bound;
   end

endmodule

@@ design/matrix_saddle_point_finder.sv @@
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder
// Loads a signed matrix element by element and reports its saddle elements.
// ----------------------------------------------------------------------------
// Elements enter in row-major order, one per cycle, while busy is low; row
// maxima and column minima are kept as they load. The beat that carries the
// last element starts a scan that reads the element store once per cycle
// through its single read port and checks each element with the one shared
// compare unit; busy stays high through the scan and the states that follow it.
// Results leave on rsp_strobe, at most one per cycle, in row-major order,
// the final one with rsp_last set; the receiver cannot stall them. With no
// saddle element a single beat with rsp_found low is sent. A size write
// abandons a partly loaded matrix.
module matrix_saddle_point_finder #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [msp_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic signed [msp_pkg::DATA_W-1:0]   rsp_element,
   output logic [msp_pkg::IDX_W-1:0]           rsp_row_index,
   output logic [msp_pkg::IDX_W-1:0]           rsp_col_index,
   output logic                                rsp_found,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [msp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msp_pkg::CSR_W-1:0]           csr_data
);

   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = 2 * DW;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   function automatic logic [DW-1:0] last_of(input logic [msp_pkg::CSR_W-1:0] d);
      logic [msp_pkg::CSR_W-1:0] lim;
      lim = msp_pkg::CSR_W'(MAX_DIM);
      if (d == '0) begin
         return '0;
      end else if (d > lim) begin
         return DW'(MAX_DIM - 1);
      end else begin
         return DW'(d - msp_pkg::CSR_W'(1));
      end
   endfunction

   logic [1:0]    state_ff, state_in;
   logic [DW-1:0] row_last_ff, row_last_in;
   logic [DW-1:0] col_last_ff, col_last_in;
   logic [DW-1:0] load_row_ff, load_row_in;
   logic [DW-1:0] load_col_ff, load_col_in;
   logic [DW-1:0] scan_row_ff, scan_row_in;
   logic [DW-1:0] scan_col_ff, scan_col_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_end_ff, s2_end_in;
   logic [DW-1:0] s2_row_ff, s2_row_in;
   logic [DW-1:0] s2_col_ff, s2_col_in;
   logic          pend_valid_ff, pend_valid_in;
   msp_pkg::data_type pend_elem_ff, pend_elem_in;
   logic [DW-1:0] pend_row_ff, pend_row_in;
   logic [DW-1:0] pend_col_ff, pend_col_in;
   logic          strobe_ff, strobe_in;
   msp_pkg::data_type out_elem_ff, out_elem_in;
   logic [DW-1:0] out_row_ff, out_row_in;
   logic [DW-1:0] out_col_ff, out_col_in;
   logic          out_found_ff, out_found_in;
   logic          out_last_ff, out_last_in;

   msp_pkg::data_type row_max_ff [MAX_DIM];
   msp_pkg::data_type col_min_ff [MAX_DIM];

   logic                   accept;
   logic                   row_max_we;
   logic                   col_min_we;
   logic                   hit;
   logic [AW-1:0]          rd_addr;
   msp_pkg::data_type      rd_data;
   msp_pkg::data_type      cmp_operand;
   msp_pkg::data_type      cmp_row_bound;
   msp_pkg::data_type      cmp_col_bound;
   msp_pkg::cmp_result_type cmp_res;

   assign busy   = state_ff != ST_LOAD;
   assign accept = start && !busy;

   msp_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({load_row_ff, load_col_ff}),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = {scan_row_ff, scan_col_ff};

   always_comb begin
      if (busy) begin
         cmp_operand   = rd_data;
         cmp_row_bound = row_max_ff[s2_row_ff];
         cmp_col_bound = col_min_ff[s2_col_ff];
      end else begin
         cmp_operand   = req_value;
         cmp_row_bound = row_max_ff[load_row_ff];
         cmp_col_bound = col_min_ff[load_col_ff];
      end
   end

   msp_cmp u_cmp (
      .operand   (cmp_operand),
      .row_bound (cmp_row_bound),
      .col_bound (cmp_col_bound),
      .result    (cmp_res)
   );

   assign row_max_we = accept && (load_col_ff == '0 || cmp_res.gt_row);
   assign col_min_we = accept && (load_row_ff == '0 || cmp_res.lt_col);
   assign hit        = s2_valid_ff && cmp_res.eq_row && cmp_res.eq_col;

   always_comb begin
      state_in      = state_ff;
      row_last_in   = row_last_ff;
      col_last_in   = col_last_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      s2_valid_in   = 1'b0;
      s2_end_in     = 1'b0;
      s2_row_in     = scan_row_ff;
      s2_col_in     = scan_col_ff;
      pend_valid_in = pend_valid_ff;
      pend_elem_in  = pend_elem_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      strobe_in     = 1'b0;
      out_elem_in   = out_elem_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_found_in  = out_found_ff;
      out_last_in   = out_last_ff;

      if (csr_write) begin
         if (csr_index == msp_pkg::CSR_ROW_COUNT) begin
            load_row_in = '0;
            load_col_in = '0;
            row_last_in = last_of(csr_data);
         end else if (csr_index == msp_pkg::CSR_COL_COUNT) begin
            load_row_in = '0;
            load_col_in = '0;
            col_last_in = last_of(csr_data);
         end
      end

      // hold the newest hit back one step so the final one can carry last
      if (hit) begin
         if (pend_valid_ff) begin
            strobe_in    = 1'b1;
            out_elem_in  = pend_elem_ff;
            out_row_in   = pend_row_ff;
            out_col_in   = pend_col_ff;
            out_found_in = 1'b1;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_elem_in  = rd_data;
         pend_row_in   = s2_row_ff;
         pend_col_in   = s2_col_ff;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (load_col_ff == col_last_ff) begin
                  load_col_in = '0;
                  if (load_row_ff == row_last_ff) begin
                     load_row_in   = '0;
                     scan_row_in   = '0;
                     scan_col_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end else begin
                     load_row_in = load_row_ff + DW'(1);
                  end
               end else begin
                  load_col_in = load_col_ff + DW'(1);
               end
            end
         end
         ST_SCAN: begin
            s2_valid_in = 1'b1;
            if (scan_col_ff == col_last_ff) begin
               scan_col_in = '0;
               if (scan_row_ff == row_last_ff) begin
                  s2_end_in = 1'b1;
                  state_in  = ST_DRAIN;
               end else begin
                  scan_row_in = scan_row_ff + DW'(1);
               end
            end else begin
               scan_col_in = scan_col_ff + DW'(1);
            end
         end
         ST_DRAIN: begin
            if (s2_end_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            strobe_in     = 1'b1;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               out_elem_in  = pend_elem_ff;
               out_row_in   = pend_row_ff;
               out_col_in   = pend_col_ff;
               out_found_in = 1'b1;
            end else begin
               out_elem_in  = '0;
               out_row_in   = '0;
               out_col_in   = '0;
               out_found_in = 1'b0;
            end
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         row_last_ff   <= DW'(MAX_DIM - 1);
         col_last_ff   <= DW'(MAX_DIM - 1);
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         s2_valid_ff   <= 1'b0;
         s2_end_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_last_ff   <= row_last_in;
         col_last_ff   <= col_last_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         s2_valid_ff   <= s2_valid_in;
         s2_end_ff     <= s2_end_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_row_ff    <= s2_row_in;
      s2_col_ff    <= s2_col_in;
      pend_elem_ff <= pend_elem_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      out_elem_ff  <= out_elem_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
      if (row_max_we) begin
         row_max_ff[load_row_ff] <= req_value;
      end
      if (col_min_we) begin
         col_min_ff[load_col_ff] <= req_value;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_element   = out_elem_ff;
   assign rsp_row_index = msp_pkg::IDX_W'(out_row_ff);
   assign rsp_col_index = msp_pkg::IDX_W'(out_col_ff);
   assign rsp_found     = out_found_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ tb/matrix_saddle_point_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder_tb
// Self-checking bench for the saddle point search block.
// ----------------------------------------------------------------------------
// Loads signed matrices element by element under random sender gaps and
// a range of size settings, zero and oversized among them. A behavioral
// model of the search predicts every saddle beat. Each rsp_strobe beat is
// compared with the oldest predicted one. The directed tasks cover:
//   - single-cell matrices and the extreme element values
//   - a matrix with no saddle element
//   - writes to unused register indexes in the middle of a load
//   - a partly loaded matrix abandoned by a size write
//   - ties
//   - a saturated row count
// The random phase then runs mostly complete matrices, with some cut short.
module matrix_saddle_point_finder_tb;

   localparam int MAX_DIM        = 8;
   localparam int SETTLE_CYCLES  = MAX_DIM * MAX_DIM + 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 246;
   localparam int REPORT_LIMIT   = 10;

   localparam msp_pkg::data_type VAL_MIN = 32'sh8000_0000;
   localparam msp_pkg::data_type VAL_MAX = 32'sh7fff_ffff;

   localparam logic [msp_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [msp_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum int unsigned {
      KIND_WIDE,
      KIND_NARROW,
      KIND_EDGE,
      KIND_MIXED
   } value_kind_type;

   typedef struct packed {
      msp_pkg::data_type         element;
      logic [msp_pkg::IDX_W-1:0] row_idx;
      logic [msp_pkg::IDX_W-1:0] col_idx;
      logic                      found;
      logic                      last;
   } saddle_type;

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic                          busy;
   msp_pkg::data_type             req_value = '0;
   logic                          rsp_strobe;
   msp_pkg::data_type             rsp_element;
   logic [msp_pkg::IDX_W-1:0]     rsp_row_index;
   logic [msp_pkg::IDX_W-1:0]     rsp_col_index;
   logic                          rsp_found;
   logic                          rsp_last;
   logic                          csr_write = 1'b0;
   logic [msp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [msp_pkg::CSR_W-1:0]     csr_data  = '0;

   // search model state
   logic [msp_pkg::CSR_W-1:0] row_setting = 4'd8;
   logic [msp_pkg::CSR_W-1:0] col_setting = 4'd8;
   msp_pkg::data_type         cell_mem [64];
   msp_pkg::data_type         row_peak [8];
   msp_pkg::data_type         col_floor [8];
   int unsigned               load_pos = 0;

   saddle_type saddles_due [$];
   int         mismatches   = 0;
   int         quiet_cycles = 0;
   bit         burst_mode   = 1'b0;

   matrix_saddle_point_finder #(
      .MAX_DIM(MAX_DIM)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_element  (rsp_element),
      .rsp_row_index(rsp_row_index),
      .rsp_col_index(rsp_col_index),
      .rsp_found    (rsp_found),
      .rsp_last     (rsp_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned dim_of(input logic [msp_pkg::CSR_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_DIM) return MAX_DIM;
      return 32'(setting);
   endfunction

   // load one element; on the last one of a matrix, queue its saddle beats
   task automatic load_and_scan(input msp_pkg::data_type v);
      int unsigned       rows, cols, total, p, r, c;
      msp_pkg::data_type e;
      saddle_type        held;
      bit                have_held;
      rows      = dim_of(row_setting);
      cols      = dim_of(col_setting);
      total     = rows * cols;
      p         = load_pos;
      have_held = 1'b0;
      if (p >= total) p = 0;
      r = p / cols;
      c = p % cols;
      cell_mem[p] = v;
      if (c == 0 || v > row_peak[r]) row_peak[r] = v;
      if (r == 0 || v < col_floor[c]) col_floor[c] = v;
      if (p + 1 < total) begin
         load_pos = p + 1;
         return;
      end
      load_pos = 0;
      for (int unsigned i = 0; i < rows; i++) begin
         for (int unsigned j = 0; j < cols; j++) begin
            e = cell_mem[i * cols + j];
            if (e == row_peak[i] && e == col_floor[j]) begin
               if (have_held) saddles_due.push_back(held);
               held      = '{e, msp_pkg::IDX_W'(i), msp_pkg::IDX_W'(j), 1'b1, 1'b0};
               have_held = 1'b1;
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         saddles_due.push_back(held);
      end else begin
         saddles_due.push_back('{'0, '0, '0, 1'b0, 1'b1});
      end
   endtask

   // called at a rising edge; returns at the edge that takes the beat
   task automatic send_element(input msp_pkg::data_type v);
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      load_and_scan(v);
   endtask

   // drain, let any scan finish, then write one register
   task automatic write_size(input logic [msp_pkg::CSR_IDX_W-1:0] idx,
                             input logic [msp_pkg::CSR_W-1:0] val);
      start <= 1'b0;
      while (saddles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == msp_pkg::CSR_ROW_COUNT) begin
         row_setting = val;
         load_pos    = 0;
      end else if (idx == msp_pkg::CSR_COL_COUNT) begin
         col_setting = val;
         load_pos    = 0;
      end
   endtask

   task automatic set_dims(input logic [msp_pkg::CSR_W-1:0] rows,
                           input logic [msp_pkg::CSR_W-1:0] cols);
      write_size(msp_pkg::CSR_ROW_COUNT, rows);
      write_size(msp_pkg::CSR_COL_COUNT, cols);
   endtask

   function automatic msp_pkg::data_type draw_value(input value_kind_type kind);
      value_kind_type pick;
      pick = (kind == KIND_MIXED) ? value_kind_type'($urandom_range(0, 2)) : kind;
      case (pick)
         KIND_WIDE:   return msp_pkg::data_type'($urandom);
         KIND_NARROW: return msp_pkg::data_type'($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 5))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return 0;
               3:       return -1;
               4:       return VAL_MIN + 1;
               default: return VAL_MAX - 1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [msp_pkg::CSR_W-1:0] draw_dim();
      case ($urandom_range(0, 15))
         0:       return 4'd0;
         1:       return msp_pkg::CSR_W'($urandom_range(MAX_DIM + 1, 15));
         2:       return msp_pkg::CSR_W'(MAX_DIM);
         3, 4:    return msp_pkg::CSR_W'($urandom_range(4, MAX_DIM - 1));
         default: return msp_pkg::CSR_W'($urandom_range(1, 3));
      endcase
   endfunction

   task automatic test_single_cell();
      set_dims(4'd1, 4'd1);
      send_element(VAL_MIN);
      send_element(VAL_MAX);
      set_dims(4'd0, 4'd0);
      send_element(0);
      send_element(-1);
   endtask

   task automatic test_no_saddle();
      set_dims(4'd2, 4'd2);
      send_element(1);
      send_element(2);
      send_element(2);
      send_element(1);
   endtask

   task automatic test_spare_index();
      send_element(-1);
      send_element(VAL_MIN);
      write_size(CSR_SPARE_A, 4'hf);
      write_size(CSR_SPARE_B, 4'h5);
      send_element(VAL_MAX);
      send_element(0);
   endtask

   task automatic test_abandon_and_ties();
      send_element(7);
      send_element(8);
      send_element(9);
      write_size(msp_pkg::CSR_ROW_COUNT, 4'd2);
      repeat (4) send_element(5);
   endtask

   task automatic test_saturated_rows();
      set_dims(4'd15, 4'd1);
      send_element(3);
      send_element(-2);
      send_element(VAL_MIN);
      send_element(4);
      send_element(VAL_MIN);
      send_element(0);
      send_element(VAL_MAX);
      send_element(-1);
   endtask

   task automatic test_random_matrices(input int unsigned item_goal);
      int unsigned    sent, total, count, n_mats;
      int             spare_at;
      value_kind_type kind;
      sent = 0;
      while (sent < item_goal) begin
         set_dims(draw_dim(), draw_dim());
         total  = dim_of(row_setting) * dim_of(col_setting);
         n_mats = $urandom_range(1, 3);
         for (int m = 0; m < n_mats; m++) begin
            kind       = value_kind_type'($urandom_range(0, 4) % 4);
            burst_mode = ($urandom_range(0, 3) == 0);
            count      = total;
            spare_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : -1;
            if (total > 1 && $urandom_range(0, 9) == 0) count = $urandom_range(1, total - 1);
            for (int k = 0; k < count; k++) begin
               if (k == spare_at)
                  write_size($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                             msp_pkg::CSR_W'($urandom_range(0, 15)));
               send_element(draw_value(kind));
            end
            sent += count;
            if (count < total || sent >= item_goal) break;
         end
      end
      burst_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      saddle_type seen, want;
      seen = {rsp_element, rsp_row_index, rsp_col_index, rsp_found, rsp_last};
      if (!reset && rsp_strobe) begin
         if (saddles_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected beat: element %0d row %0d col %0d found %0b last %0b",
                        $realtime, seen.element, seen.row_idx, seen.col_idx, seen.found,
                        seen.last);
         end else begin
            want = saddles_due.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"%0t: mismatch: expected element %0d row %0d col %0d found %0b ",
                            "last %0b, got element %0d row %0d col %0d found %0b last %0b"},
                           $realtime, want.element, want.row_idx, want.col_idx, want.found,
                           want.last, seen.element, seen.row_idx, seen.col_idx, seen.found,
                           seen.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_write) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[matrix_saddle_point_finder] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_cell();
      test_no_saddle();
      test_spare_index();
      test_abandon_and_ties();
      test_saturated_rows();
      test_random_matrices(RANDOM_ITEMS);
      start <= 1'b0;
      while (saddles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && saddles_due.size() == 0) begin
         $display("[matrix_saddle_point_finder] OK");
      end else begin
         $display("[matrix_saddle_point_finder] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/msp_pkg.sv
design/msp_store.sv
design/msp_cmp.sv
design/matrix_saddle_point_finder.sv
tb/matrix_saddle_point_finder_tb.sv
